// ===== sv/lbc_pkg.sv =====
// shared types and constants of the led blink controller
// no dependencies; every other file imports this package

package lbc_pkg;

    // number of leds in use, from 1 to 16
    localparam int NUM_LEDS    = 16;
    localparam int LED_IDX_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    // field widths of the channels
    localparam int LED_FIELD_W = 16;
    localparam int OPCODE_W    = 2;
    localparam int MODE_W      = 2;
    localparam int COUNT_W     = 8;
    localparam int DUTY_IN_W   = 8;
    localparam int PCT_W       = 7;
    localparam int PERIOD_W    = 16;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEF_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_DUTY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_PERIOD = 2'd2;

    localparam logic [COUNT_W-1:0]  DEF_COUNT_RST  = 8'd1;
    localparam logic [PCT_W-1:0]    DEF_DUTY_RST   = 7'd50;
    localparam logic [PERIOD_W-1:0] DEF_PERIOD_RST = 16'd1000;

    // percent arithmetic: x / 100 as (x * ceil(2^30 / 100)) >> 30, exact below 2^23
    localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
    localparam int               PROD_W       = PCT_W + PERIOD_W;
    localparam int               RECIP_W      = 24;
    localparam int               DIV100_SHIFT = 30;
    localparam int unsigned      DIV100_RECIP = ((32'd1 << DIV100_SHIFT) + 32'd99) / 32'd100;
    localparam int               QUOT_FULL_W  = PROD_W + RECIP_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_STEADY  = 2'd0,
        OP_DEFAULT = 2'd1,
        OP_BLINK   = 2'd2,
        OP_TICK    = 2'd3
    } t_opcode;

    // steady_mode codes for the steady command
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd2;
    // steady_mode codes for the default blink command
    localparam logic [MODE_W-1:0] MODE_BLINK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FLASH  = 2'd1;

    // resolved action of one command, applied led by led
    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_OFF    = 3'd1,
        ACT_ON     = 3'd2,
        ACT_TOGGLE = 3'd3,
        ACT_ARM    = 3'd4,
        ACT_TICK   = 3'd5
    } t_action;

    typedef struct packed {
        logic cont;
        logic blink;
        logic on;
    } t_led_flags;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SWEEP = 2'd1,
        ST_DONE  = 2'd2
    } t_ctrl_state;

    // controller to datapath commands
    typedef struct packed {
        logic                 capture;
        logic                 step;
        logic [LED_IDX_W-1:0] idx;
        logic                 load_out;
    } t_dp_cmd;

endpackage

// ===== sv/lbc_cmd_if.sv =====
// command channel of the led blink controller: valid, ready and command payload
// depends on lbc_pkg

interface lbc_cmd_if;
    import lbc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [LED_FIELD_W-1:0] led_mask;
    logic [MODE_W-1:0]      steady_mode;
    logic [COUNT_W-1:0]     blink_count;
    logic [DUTY_IN_W-1:0]   duty_pct;
    logic [PERIOD_W-1:0]    period_ticks;

    modport source (
        output valid, opcode, led_mask, steady_mode, blink_count, duty_pct, period_ticks,
        input  ready
    );

    modport sink (
        input  valid, opcode, led_mask, steady_mode, blink_count, duty_pct, period_ticks,
        output ready
    );
endinterface

// ===== sv/lbc_res_if.sv =====
// result channel of the led blink controller: valid, ready and led status payload
// depends on lbc_pkg

interface lbc_res_if;
    import lbc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [LED_FIELD_W-1:0] led_levels;
    logic [LED_FIELD_W-1:0] blinking_mask;

    modport source (
        output valid, led_levels, blinking_mask,
        input  ready
    );

    modport sink (
        input  valid, led_levels, blinking_mask,
        output ready
    );
endinterface

// ===== sv/lbc_ctrl.sv =====
// sequencer of the led blink controller: command intake, per-led sweep, result handoff
// depends on lbc_pkg

module lbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output lbc_pkg::t_dp_cmd o_cmd
);
    import lbc_pkg::*;

    t_ctrl_state          r_state, n_state;
    logic [LED_IDX_W-1:0] r_idx, n_idx;
    logic                 r_out_valid, n_out_valid;
    logic                 w_last;
    logic                 w_out_free;

    assign w_last     = (r_idx == LED_IDX_W'(NUM_LEDS - 1));
    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.load_out = 1'b0;
        o_cmd.idx      = r_idx;
        n_idx          = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                // no beat is taken while reset is held
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
                n_idx         = '0;
            end
            ST_SWEEP: begin
                o_cmd.step = 1'b1;
                n_idx      = w_last ? '0 : r_idx + 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = w_out_free;
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/lbc_datapath.sv =====
// datapath of the led blink controller: command decode, per-led state, blink timing
// depends on lbc_pkg; driven by lbc_ctrl through t_dp_cmd

module lbc_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lbc_pkg::t_dp_cmd                i_cmd,
    input  logic [lbc_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic [lbc_pkg::LED_FIELD_W-1:0] i_led_mask,
    input  logic [lbc_pkg::MODE_W-1:0]      i_steady_mode,
    input  logic [lbc_pkg::COUNT_W-1:0]     i_blink_count,
    input  logic [lbc_pkg::DUTY_IN_W-1:0]   i_duty_pct,
    input  logic [lbc_pkg::PERIOD_W-1:0]    i_period_ticks,
    input  logic                            i_cfg_we,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [lbc_pkg::LED_FIELD_W-1:0] o_led_levels,
    output logic [lbc_pkg::LED_FIELD_W-1:0] o_blinking_mask
);
    import lbc_pkg::*;

    // configuration
    logic [COUNT_W-1:0]  r_def_count;
    logic [PCT_W-1:0]    r_def_duty;
    logic [PERIOD_W-1:0] r_def_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_count  <= DEF_COUNT_RST;
            r_def_duty   <= DEF_DUTY_RST;
            r_def_period <= DEF_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEF_COUNT:  r_def_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_DEF_DUTY:   r_def_duty   <= i_cfg_data[PCT_W-1:0];
                CFG_DEF_PERIOD: r_def_period <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // command decode at capture
    t_action               n_act, r_act;
    logic                  w_is_arm;
    logic [COUNT_W-1:0]    w_arm_count;
    logic [DUTY_IN_W-1:0]  w_arm_duty;
    logic [PERIOD_W-1:0]   w_arm_period;
    logic [NUM_LEDS-1:0]   w_mask;
    logic [NUM_LEDS-1:0]   r_mask;
    logic [COUNT_W-1:0]    r_count;
    logic [PCT_W-1:0]      r_duty;
    logic [PERIOD_W-1:0]   r_period;

    assign w_mask = i_led_mask[NUM_LEDS-1:0];

    always_comb begin
        n_act        = ACT_NONE;
        w_is_arm     = 1'b0;
        w_arm_count  = i_blink_count;
        w_arm_duty   = i_duty_pct;
        w_arm_period = i_period_ticks;
        unique case (i_opcode)
            OP_STEADY: begin
                unique case (i_steady_mode)
                    MODE_OFF:    n_act = ACT_OFF;
                    MODE_ON:     n_act = ACT_ON;
                    MODE_TOGGLE: n_act = ACT_TOGGLE;
                    default:     n_act = ACT_NONE;
                endcase
            end
            OP_DEFAULT: begin
                w_arm_duty   = DUTY_IN_W'(r_def_duty);
                w_arm_period = r_def_period;
                if (i_steady_mode == MODE_BLINK) begin
                    w_is_arm    = 1'b1;
                    w_arm_count = r_def_count;
                end else if (i_steady_mode == MODE_FLASH) begin
                    w_is_arm    = 1'b1;
                    w_arm_count = '0;
                end
            end
            OP_BLINK: begin
                w_is_arm = 1'b1;
            end
            default: begin
                n_act = ACT_TICK;
            end
        endcase
        if (w_is_arm) begin
            if (w_mask == '0) begin
                n_act = ACT_NONE;
            end else if (w_arm_duty == '0 || w_arm_period == '0) begin
                n_act = ACT_OFF;
            end else if (w_arm_duty >= DUTY_IN_W'(PCT_FULL)) begin
                n_act = ACT_ON;
            end else begin
                n_act = ACT_ARM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= ACT_NONE;
        end else if (i_cmd.capture) begin
            r_act <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mask   <= w_mask;
            r_count  <= w_arm_count;
            r_duty   <= w_arm_duty[PCT_W-1:0];
            r_period <= w_arm_period;
        end
    end

    // per-led state
    logic [NUM_LEDS-1:0] r_level;
    logic [NUM_LEDS-1:0] r_saved;
    t_led_flags          r_flags  [NUM_LEDS];
    logic [COUNT_W-1:0]  r_blinks [NUM_LEDS];
    logic [PCT_W-1:0]    r_onp    [NUM_LEDS];
    logic [PERIOD_W-1:0] r_cycle  [NUM_LEDS];
    logic [PERIOD_W-1:0] r_ticks  [NUM_LEDS];

    // stage one: update of the led at the sweep index
    logic [LED_IDX_W-1:0] w_idx;
    logic                 w_sel;
    t_led_flags           w_f;
    logic [PERIOD_W-1:0]  w_t_dec;
    t_led_flags           n_flags;
    logic                 n_level_bit;
    logic                 n_saved_bit;
    logic [COUNT_W-1:0]   n_blinks;
    logic                 w_wr_flags, w_wr_level, w_wr_saved, w_wr_blinks, w_wr_arm;
    logic                 n_s2_valid, n_s2_div;
    logic [PERIOD_W-1:0]  n_s2_direct;
    logic [PCT_W-1:0]     w_pct;
    logic [PROD_W-1:0]    n_s2_prod;

    assign w_idx     = i_cmd.idx;
    assign w_sel     = r_mask[w_idx];
    assign w_f       = r_flags[w_idx];
    assign w_t_dec   = (r_ticks[w_idx] != '0) ? r_ticks[w_idx] - 1'b1 : r_ticks[w_idx];
    assign n_s2_prod = PROD_W'(w_pct) * PROD_W'(r_cycle[w_idx]);

    always_comb begin
        n_flags     = w_f;
        n_level_bit = r_level[w_idx];
        n_saved_bit = r_saved[w_idx];
        n_blinks    = r_blinks[w_idx];
        w_wr_flags  = 1'b0;
        w_wr_level  = 1'b0;
        w_wr_saved  = 1'b0;
        w_wr_blinks = 1'b0;
        w_wr_arm    = 1'b0;
        n_s2_valid  = 1'b0;
        n_s2_div    = 1'b0;
        n_s2_direct = '0;
        w_pct       = r_onp[w_idx];
        if (i_cmd.step) begin
            case (r_act)
                ACT_OFF, ACT_ON: begin
                    if (w_sel) begin
                        n_flags     = '{cont: 1'b0, blink: 1'b0, on: (r_act == ACT_ON)};
                        n_level_bit = (r_act == ACT_ON);
                        w_wr_flags  = 1'b1;
                        w_wr_level  = 1'b1;
                    end
                end
                ACT_TOGGLE: begin
                    if (w_sel) begin
                        n_flags.on  = !w_f.on;
                        n_level_bit = !w_f.on;
                        w_wr_flags  = 1'b1;
                        w_wr_level  = 1'b1;
                    end
                end
                ACT_ARM: begin
                    if (w_sel) begin
                        // a led already blinking keeps its saved level
                        if (!w_f.blink) begin
                            n_saved_bit = r_level[w_idx];
                            w_wr_saved  = 1'b1;
                        end
                        n_flags     = '{cont: (r_count == '0), blink: 1'b1, on: 1'b0};
                        n_blinks    = r_count;
                        w_wr_flags  = 1'b1;
                        w_wr_blinks = 1'b1;
                        w_wr_arm    = 1'b1;
                        n_s2_valid  = 1'b1;
                    end
                end
                ACT_TICK: begin
                    if (w_f.blink) begin
                        n_s2_valid = 1'b1;
                        w_wr_flags = 1'b1;
                        if (w_t_dec != '0) begin
                            n_s2_direct = w_t_dec;
                        end else if (w_f.on) begin
                            // end of on phase
                            w_pct       = PCT_FULL - r_onp[w_idx];
                            n_flags.on  = 1'b0;
                            n_level_bit = 1'b0;
                            w_wr_level  = 1'b1;
                            n_s2_div    = 1'b1;
                            if (!w_f.cont) begin
                                n_blinks    = r_blinks[w_idx] - 1'b1;
                                w_wr_blinks = 1'b1;
                            end
                        end else if (r_blinks[w_idx] == '0 && !w_f.cont) begin
                            // count used up: back to the level before the blink
                            n_flags     = '0;
                            n_level_bit = r_saved[w_idx];
                            n_saved_bit = 1'b0;
                            w_wr_level  = 1'b1;
                            w_wr_saved  = 1'b1;
                        end else begin
                            // start of on phase
                            n_flags.on  = 1'b1;
                            n_level_bit = 1'b1;
                            w_wr_level  = 1'b1;
                            n_s2_div    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_saved <= '0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_flags[i] <= '0;
            end
        end else begin
            if (w_wr_flags) begin
                r_flags[w_idx] <= n_flags;
            end
            if (w_wr_level) begin
                r_level[w_idx] <= n_level_bit;
            end
            if (w_wr_saved) begin
                r_saved[w_idx] <= n_saved_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_blinks) begin
            r_blinks[w_idx] <= n_blinks;
        end
        if (w_wr_arm) begin
            r_onp[w_idx]   <= r_duty;
            r_cycle[w_idx] <= r_period;
        end
    end

    // stage two: write the tick counter, a new phase length divided by 100 or a direct value
    logic                 r_s2_valid;
    logic                 r_s2_div;
    logic [LED_IDX_W-1:0] r_s2_idx;
    logic [PERIOD_W-1:0]  r_s2_direct;
    logic [PROD_W-1:0]    r_s2_prod;
    logic [QUOT_FULL_W-1:0] w_quot_full;
    logic [PERIOD_W-1:0]  w_quot;

    assign w_quot_full = QUOT_FULL_W'(r_s2_prod) * QUOT_FULL_W'(DIV100_RECIP);
    assign w_quot      = w_quot_full[DIV100_SHIFT +: PERIOD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_div    <= n_s2_div;
        r_s2_idx    <= w_idx;
        r_s2_direct <= n_s2_direct;
        r_s2_prod   <= n_s2_prod;
        if (r_s2_valid) begin
            r_ticks[r_s2_idx] <= r_s2_div ? w_quot : r_s2_direct;
        end
    end

    // result register
    logic [NUM_LEDS-1:0]    w_blinking;
    logic [LED_FIELD_W-1:0] r_out_levels;
    logic [LED_FIELD_W-1:0] r_out_blinking;

    always_comb begin
        for (int i = 0; i < NUM_LEDS; i++) begin
            w_blinking[i] = r_flags[i].blink;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_levels   <= LED_FIELD_W'(r_level);
            r_out_blinking <= LED_FIELD_W'(w_blinking);
        end
    end

    assign o_led_levels    = r_out_levels;
    assign o_blinking_mask = r_out_blinking;

endmodule

// ===== sv/led_blink_controller.sv =====
// top level of the led blink controller
// depends on lbc_pkg, lbc_cmd_if, lbc_res_if, lbc_ctrl and lbc_datapath
//
// usage
// - i_cmd carries one command per beat: steady off/on/toggle, default blink or
//   flash, blink with given count, duty and period, or a tick of elapsed time
// - o_res returns exactly one beat per command: the led levels and the mask of
//   leds still blinking, both as they stand after the command
// - the default count, duty and period are written on the cfg port, index 0, 1
//   and 2; write them only while no command is in flight
// timing
// - a command is taken in the idle cycle, then one shared update unit visits
//   each led in turn, one led per cycle, followed by the done state, which
//   finishes the last tick-counter write and hands off the result
// - a command is taken only in the idle state, after the previous result went to the output register
// reset and stall
// - synchronous active-low reset puts all leds off, no blink armed, defaults
//   to count 1, duty 50, period 1000, and clears o_res.valid
// - a result waits in the output register while o_res.ready is low; the next
//   command is still accepted and swept, and only its handoff waits

module led_blink_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lbc_cmd_if.sink                        i_cmd,
    lbc_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lbc_pkg::*;

    t_dp_cmd w_dp_cmd;   // sequencer commands to the datapath
    logic    w_in_ready;
    logic    w_out_valid;

    lbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_dp_cmd)
    );

    lbc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_dp_cmd),
        .i_opcode        (i_cmd.opcode),
        .i_led_mask      (i_cmd.led_mask),
        .i_steady_mode   (i_cmd.steady_mode),
        .i_blink_count   (i_cmd.blink_count),
        .i_duty_pct      (i_cmd.duty_pct),
        .i_period_ticks  (i_cmd.period_ticks),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_led_levels    (o_res.led_levels),
        .o_blinking_mask (o_res.blinking_mask)
    );

    assign i_cmd.ready = w_in_ready;
    assign o_res.valid = w_out_valid;

    // no new command while the sweep is running
    a_no_accept_in_sweep: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_dp_cmd.step |-> !w_in_ready
    ) else $error("command ready during led sweep");

    // an accepted command starts the sweep at led 0 on the next cycle
    a_sweep_starts: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && w_in_ready) |=> (w_dp_cmd.step && w_dp_cmd.idx == '0)
    ) else $error("sweep did not start after accept");

    // the result register is never loaded over an untaken beat
    a_no_result_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_dp_cmd.load_out |-> (!w_out_valid || o_res.ready)
    ) else $error("result register overwritten while stalled");

endmodule
